@@ rtl/core/abt_pkg.sv @@
// Package for the affine block transposition unit.
// Holds shared widths, register indexes, sequencer states and the request
// struct of the modular adder. No dependencies.
`default_nettype none

package abt_pkg;

    // Largest block in bytes
    localparam int MAX_BLOCK = 16;

    localparam int BYTE_W    = 8;
    localparam int CFG_LEN_W = 5;
    localparam int KEY_W     = 4;
    localparam int CFG_W     = CFG_LEN_W;
    localparam int CFG_IDX_W = 2;

    localparam int IDX_W   = $clog2(MAX_BLOCK);
    localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
    localparam int LEN_W   = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;
    localparam int BIT_W   = $clog2(KEY_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RMUL = 4'b0010,
        S_ROFF = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // Operands of one modular add: (a + b + cin) reduced once by n
    typedef struct packed {
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
        logic             cin;
        logic [LEN_W-1:0] n;
    } t_mod_req;

endpackage

`default_nettype wire

@@ rtl/core/abt_mod_unit.sv @@
// Shared modular adder: one add and one conditional subtract.
// Depends on abt_pkg for t_mod_req and widths.
`default_nettype none

module abt_mod_unit
    import abt_pkg::*;
(
    input  wire t_mod_req          i_req,
    output logic [LEN_W-1:0]       o_res
);

    logic [LEN_W:0] sum;
    logic [LEN_W:0] n_ext;

    // Add, then reduce once; operands keep the sum below twice the modulus
    always_comb begin
        sum   = {1'b0, i_req.a} + {1'b0, i_req.b} + {{LEN_W{1'b0}}, i_req.cin};
        n_ext = {1'b0, i_req.n};
        if (sum >= n_ext) begin
            o_res = LEN_W'(sum - n_ext);
        end else begin
            o_res = LEN_W'(sum);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/affine_block_transposition_unit.sv @@
// Top level of the affine block transposition unit: byte buffer, sequencer
// and output register. Depends on abt_pkg and abt_mod_unit.
`default_nettype none

// Bytes are taken one per transaction and stored in a block buffer. A byte
// that does not complete a block leaves the input open. The byte that
// completes a block (fill reaches block_len, or end_of_message is set)
// starts the burst: mult, then offset, are reduced modulo the block length
// in the shared modular adder, one key bit per cycle, then the block leaves
// at one byte per cycle while the output is not stalled. Output position i
// carries byte (mult*i+offset) mod n; source positions at or past the fill
// count read as zero padding. Input stall is high from the completing byte
// until the last byte of the block is loaded into the output register.
module affine_block_transposition_unit
    import abt_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // configuration write port
    input  wire                  i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_W-1:0]      i_cfg_data,
    // input channel
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [BYTE_W-1:0]     i_data_byte,
    input  wire                  i_end_of_message,
    // output channel
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_block_last,
    output logic                 o_message_last
);

    // Configuration registers
    logic [CFG_LEN_W-1:0] r_block_len;
    logic [KEY_W-1:0]     r_mult;
    logic [KEY_W-1:0]     r_offset;

    // Block buffer
    logic [BYTE_W-1:0]    r_buf [MAX_BLOCK];

    // Sequencer state
    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_cnt;
    logic [LEN_W-1:0]     r_mul;
    logic [LEN_W-1:0]     r_src;
    logic [LEN_W-1:0]     r_idx;
    logic [BIT_W-1:0]     r_bit;
    logic                 r_eom;

    // Output register
    logic                 r_ovalid;
    logic [BYTE_W-1:0]    r_obyte;
    logic                 r_oblast;
    logic                 r_omlast;

    logic [LEN_W-1:0]     len_ext;
    logic [LEN_W-1:0]     n_len;
    logic [LEN_W-1:0]     cnt_inc;
    logic                 in_acc;
    logic                 blk_done;
    logic                 out_free;
    logic                 emit_ld;
    logic                 pos_last;
    logic                 key_bit;
    t_mod_req             mod_req;
    logic [LEN_W-1:0]     mod_res;

    // Effective block length: zero counts as one, saturate at the buffer size
    always_comb begin
        len_ext = LEN_W'(r_block_len);
        if (len_ext == '0) begin
            n_len = LEN_W'(1);
        end else if (len_ext > LEN_W'(MAX_BLOCK)) begin
            n_len = LEN_W'(MAX_BLOCK);
        end else begin
            n_len = len_ext;
        end
    end

    assign in_acc   = i_valid && !o_stall;
    assign cnt_inc  = r_cnt + LEN_W'(1);
    assign blk_done = (cnt_inc >= n_len) || i_end_of_message;
    assign out_free = !r_ovalid || !i_stall;
    assign emit_ld  = (r_state == S_EMIT) && out_free;
    assign pos_last = (r_idx + LEN_W'(1)) == n_len;

    // Select the key bit for the Horner reduction, most significant first
    always_comb begin
        case (r_state)
            S_RMUL:  key_bit = r_mult[r_bit];
            S_ROFF:  key_bit = r_offset[r_bit];
            default: key_bit = 1'b0;
        endcase
    end

    // Route operands to the shared adder
    always_comb begin
        mod_req.n = n_len;
        case (r_state)
            S_RMUL: begin
                mod_req.a   = r_mul;
                mod_req.b   = r_mul;
                mod_req.cin = key_bit;
            end
            S_ROFF: begin
                mod_req.a   = r_src;
                mod_req.b   = r_src;
                mod_req.cin = key_bit;
            end
            default: begin
                mod_req.a   = r_src;
                mod_req.b   = r_mul;
                mod_req.cin = 1'b0;
            end
        endcase
    end

    abt_mod_unit u_mod (
        .i_req (mod_req),
        .o_res (mod_res)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && blk_done) begin
                    n_state = S_RMUL;
                end
            end
            S_RMUL: begin
                if (r_bit == '0) begin
                    n_state = S_ROFF;
                end
            end
            S_ROFF: begin
                if (r_bit == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_ld && pos_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= CFG_LEN_W'(16);
            r_mult      <= KEY_W'(1);
            r_offset    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BLOCK_LEN: r_block_len <= i_cfg_data[CFG_LEN_W-1:0];
                CFG_MULT:      r_mult      <= i_cfg_data[KEY_W-1:0];
                CFG_OFFSET:    r_offset    <= i_cfg_data[KEY_W-1:0];
                default:       ;
            endcase
        end
    end

    // Store each accepted byte at the fill position
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf[r_cnt[IDX_W-1:0]] <= i_data_byte;
        end
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_bit   <= '0;
            r_eom   <= 1'b0;
            r_mul   <= '0;
            r_src   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt <= cnt_inc;
                        if (blk_done) begin
                            r_eom <= i_end_of_message;
                            r_mul <= '0;
                            r_src <= '0;
                            r_idx <= '0;
                            r_bit <= BIT_W'(KEY_W - 1);
                        end
                    end
                end
                S_RMUL: begin
                    r_mul <= mod_res;
                    r_bit <= r_bit - BIT_W'(1);
                end
                S_ROFF: begin
                    r_src <= mod_res;
                    r_bit <= r_bit - BIT_W'(1);
                end
                S_EMIT: begin
                    if (emit_ld) begin
                        r_src <= mod_res;
                        r_idx <= r_idx + LEN_W'(1);
                        if (pos_last) begin
                            r_cnt <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: load a result when free, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_ld) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Positions at or past the fill count are zero padding
    always_ff @(posedge i_clk) begin
        if (emit_ld) begin
            if (r_src < r_cnt) begin
                r_obyte <= r_buf[r_src[IDX_W-1:0]];
            end else begin
                r_obyte <= '0;
            end
            r_oblast <= pos_last;
            r_omlast <= pos_last && r_eom;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_block_last   = r_oblast;
    assign o_message_last = r_omlast;

endmodule

`default_nettype wire

@@ rtl/core/abt_checker.sv @@
// Port-level checker for the affine block transposition unit, with its bind.
// Depends on abt_pkg for widths; attaches to affine_block_transposition_unit.
`default_nettype none

module abt_checker
    import abt_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  o_stall,
    input  wire                  o_valid,
    input  wire                  i_stall,
    input  wire [BYTE_W-1:0]     o_out_byte,
    input  wire                  o_block_last,
    input  wire                  o_message_last
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte)
            && $stable(o_block_last) && $stable(o_message_last))
        else $error("stalled output changed");

    // The final byte of a message always closes a block
    a_msg_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_last |-> o_block_last)
        else $error("message_last without block_last");

    // No new byte is taken while a block is still leaving
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_block_last |-> o_stall)
        else $error("input open during block emission");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind affine_block_transposition_unit abt_checker u_abt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_byte     (o_out_byte),
    .o_block_last   (o_block_last),
    .o_message_last (o_message_last)
);

`default_nettype wire
